### sv/ssg_pkg.sv
// Shared types and constants for the stepper segment step generator.
`default_nettype none
package ssg_pkg;

  localparam int LIMIT_WIDTH     = 31;
  localparam int COUNT_WIDTH     = 32;
  localparam int ADD_WIDTH       = 32;
  localparam int CFG_INDEX_WIDTH = 1;

  localparam logic [LIMIT_WIDTH-1:0] MIN_INTERVAL_RESET = 31'd100;
  localparam logic [LIMIT_WIDTH-1:0] MAX_INTERVAL_RESET = 31'h7FFF_FFFF;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_MIN_INTERVAL = 1'b0,
    REG_MAX_INTERVAL = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [LIMIT_WIDTH-1:0] start_interval;
    logic [COUNT_WIDTH-1:0] step_count;
    logic [ADD_WIDTH-1:0]   interval_add;
    logic                   direction;
  } item_t;

endpackage
`default_nettype wire

### sv/ssg_interval_step.sv
// Post-step interval update: signed add, clamp to min/max, saturate to width.
`default_nettype none
module ssg_interval_step #(
  parameter int INTERVAL_WIDTH = 31
) (
  input  wire logic [INTERVAL_WIDTH-1:0]      interval,
  input  wire logic [ssg_pkg::ADD_WIDTH-1:0]  delta,
  input  wire logic [ssg_pkg::LIMIT_WIDTH-1:0] min_limit,
  input  wire logic [ssg_pkg::LIMIT_WIDTH-1:0] max_limit,
  output logic      [INTERVAL_WIDTH-1:0]      result
);

  localparam int SW = ssg_pkg::ADD_WIDTH + 2;
  localparam logic [SW-1:0] TOP = SW'((64'd1 << INTERVAL_WIDTH) - 64'd1);

  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] lo;
  logic signed [SW-1:0] hi;
  logic signed [SW-1:0] after_min;
  logic signed [SW-1:0] after_max;

  // Add in a wide signed word, then clamp min and then max, then saturate to the interval width
  always_comb begin
    sum = $signed({{(SW-INTERVAL_WIDTH){1'b0}}, interval})
        + $signed({{(SW-ssg_pkg::ADD_WIDTH){delta[ssg_pkg::ADD_WIDTH-1]}}, delta});
    lo  = $signed({{(SW-ssg_pkg::LIMIT_WIDTH){1'b0}}, min_limit});
    hi  = $signed({{(SW-ssg_pkg::LIMIT_WIDTH){1'b0}}, max_limit});
    after_min = (sum < lo) ? lo : sum;
    after_max = (after_min > hi) ? hi : after_min;
    if (after_max < $signed(SW'(0))) begin
      result = '0;
    end else if (after_max > $signed(TOP)) begin
      result = TOP[INTERVAL_WIDTH-1:0];
    end else begin
      result = after_max[INTERVAL_WIDTH-1:0];
    end
  end

endmodule
`default_nettype wire

### sv/stepper_segment_step_generator.sv
// Top level of the stepper segment step generator.
// Takes one item per clock: a tick (cmd 0) advances the half-period phase
// counter while steps remain, a load (cmd 1) starts a ramp segment when no
// steps remain and its step count is nonzero, and is flagged rejected when
// steps remain. Every item gives exactly one result, which shows the step
// and direction pins, busy and the interval in use after the item. An item
// passes an input register, then one pass of phase compare and interval
// update logic writes the state and the result register, and the block
// sustains one item per clock while the result side keeps taking. The
// min and max interval registers are written through the configuration
// channel, which is always ready.
`default_nettype none
module stepper_segment_step_generator #(
  parameter int INTERVAL_WIDTH = 31
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ssg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [ssg_pkg::LIMIT_WIDTH-1:0]     cfg_data,
  // input items
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                cmd,
  input  wire logic [ssg_pkg::LIMIT_WIDTH-1:0]     seg_start_interval,
  input  wire logic [ssg_pkg::COUNT_WIDTH-1:0]     seg_step_count,
  input  wire logic signed [ssg_pkg::ADD_WIDTH-1:0] seg_interval_add,
  input  wire logic                                seg_direction,
  // results
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     step_line,
  output logic                                     direction_line,
  output logic                                     busy_res,
  output logic                                     rejected,
  output logic      [ssg_pkg::LIMIT_WIDTH-1:0]     current_interval
);

  localparam logic [ssg_pkg::LIMIT_WIDTH-1:0] IV_MAX =
    ssg_pkg::LIMIT_WIDTH'((64'd1 << INTERVAL_WIDTH) - 64'd1);

  // configuration registers
  logic [ssg_pkg::LIMIT_WIDTH-1:0] min_interval;
  logic [ssg_pkg::LIMIT_WIDTH-1:0] max_interval;

  // input stage
  logic           s1_valid;
  ssg_pkg::item_t s1_item;
  logic           advance;

  // generator state
  logic                            step_level, step_level_next;
  logic                            dir_level, dir_level_next;
  logic [ssg_pkg::COUNT_WIDTH-1:0] steps_remaining, steps_remaining_next;
  logic [INTERVAL_WIDTH-1:0]       interval_now, interval_now_next;
  logic [ssg_pkg::ADD_WIDTH-1:0]   interval_delta, interval_delta_next;
  logic [INTERVAL_WIDTH-1:0]       phase_ticks, phase_ticks_next;
  logic                            rejected_next;

  logic                      busy;
  logic [INTERVAL_WIDTH:0]   phase_inc;
  logic [INTERVAL_WIDTH-1:0] start_sat;
  logic [INTERVAL_WIDTH-1:0] interval_stepped;

  assign cfg_ready = 1'b1;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= ssg_pkg::MIN_INTERVAL_RESET;
      max_interval <= ssg_pkg::MAX_INTERVAL_RESET;
    end else if (cfg_valid) begin
      unique case (ssg_pkg::cfg_reg_t'(cfg_index))
        ssg_pkg::REG_MIN_INTERVAL: min_interval <= cfg_data;
        ssg_pkg::REG_MAX_INTERVAL: max_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // process the held item whenever the result register can take it
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // capture input transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item.cmd            <= ssg_pkg::cmd_t'(cmd);
      s1_item.start_interval <= seg_start_interval;
      s1_item.step_count     <= seg_step_count;
      s1_item.interval_add   <= seg_interval_add;
      s1_item.direction      <= seg_direction;
    end
  end

  ssg_interval_step #(
    .INTERVAL_WIDTH(INTERVAL_WIDTH)
  ) u_interval_step (
    .interval (interval_now),
    .delta    (interval_delta),
    .min_limit(min_interval),
    .max_limit(max_interval),
    .result   (interval_stepped)
  );

  assign busy      = (steps_remaining != '0);
  assign phase_inc = {1'b0, phase_ticks} + (INTERVAL_WIDTH+1)'(1);
  assign start_sat = (s1_item.start_interval > IV_MAX) ? IV_MAX[INTERVAL_WIDTH-1:0]
                                                       : s1_item.start_interval[INTERVAL_WIDTH-1:0];

  // next state: load a segment (or reject the load while busy), or advance the phase on a tick while busy
  always_comb begin
    step_level_next      = step_level;
    dir_level_next       = dir_level;
    steps_remaining_next = steps_remaining;
    interval_now_next    = interval_now;
    interval_delta_next  = interval_delta;
    phase_ticks_next     = phase_ticks;
    rejected_next        = 1'b0;
    if (s1_item.cmd == ssg_pkg::CMD_LOAD) begin
      if (busy) begin
        rejected_next = 1'b1;
      end else if (s1_item.step_count != '0) begin
        interval_now_next    = start_sat;
        steps_remaining_next = s1_item.step_count;
        interval_delta_next  = s1_item.interval_add;
        dir_level_next       = s1_item.direction;
        step_level_next      = 1'b0;
        phase_ticks_next     = '0;
      end
    end else if (busy) begin
      if (phase_inc >= {1'b0, interval_now}) begin
        phase_ticks_next = '0;
        if (!step_level) begin
          step_level_next = 1'b1;
        end else begin
          step_level_next      = 1'b0;
          interval_now_next    = interval_stepped;
          steps_remaining_next = steps_remaining - ssg_pkg::COUNT_WIDTH'(1);
        end
      end else begin
        phase_ticks_next = phase_inc[INTERVAL_WIDTH-1:0];
      end
    end
  end

  // update state once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      step_level      <= 1'b0;
      dir_level       <= 1'b0;
      steps_remaining <= '0;
      interval_now    <= '0;
      interval_delta  <= '0;
      phase_ticks     <= '0;
    end else if (advance) begin
      step_level      <= step_level_next;
      dir_level       <= dir_level_next;
      steps_remaining <= steps_remaining_next;
      interval_now    <= interval_now_next;
      interval_delta  <= interval_delta_next;
      phase_ticks     <= phase_ticks_next;
    end
  end

  // result register: hold until the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      step_line        <= step_level_next;
      direction_line   <= dir_level_next;
      busy_res         <= (steps_remaining_next != '0);
      rejected         <= rejected_next;
      current_interval <= ssg_pkg::LIMIT_WIDTH'(interval_now_next);
    end
  end

endmodule
`default_nettype wire

### sv/ssg_checker.sv
// Port-level checks for the stepper segment step generator, bound to the top.
`default_nettype none
module ssg_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic step_line,
  input wire logic busy_res,
  input wire logic rejected
);

  // a rejected load leaves the running segment busy
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> busy_res)
    else $error("rejected result without busy");

  // the step line rests low while idle
  a_idle_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && !busy_res |-> !step_line)
    else $error("step line high while idle");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stepper_segment_step_generator ssg_checker u_ssg_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .step_line(step_line),
  .busy_res (busy_res),
  .rejected (rejected)
);
`default_nettype wire

### bench/tb_stepper_segment_step_generator.sv
// Testbench for the stepper segment step generator: random ramp segments against a predictor.
`timescale 1ns / 1ps

module tb_stepper_segment_step_generator;

  localparam int    RUN_LIMIT   = 400000;
  localparam int    LONG_HOLD   = 300;
  localparam int    PER_PHASE   = 360;
  localparam int    NUM_PHASES  = 5;
  localparam int    DRAIN_WAIT  = 6;
  localparam longint IV_TOP     = (longint'(1) << ssg_pkg::LIMIT_WIDTH) - 1;

  typedef struct packed {
    logic                            step;
    logic                            dir;
    logic                            busy;
    logic                            rej;
    logic [ssg_pkg::LIMIT_WIDTH-1:0] interval;
  } pin_state_t;

  // Track clamp registers and motion state, queue the pin levels each item should give
  class step_gen_scoreboard;
    logic [ssg_pkg::LIMIT_WIDTH-1:0] min_iv;
    logic [ssg_pkg::LIMIT_WIDTH-1:0] max_iv;
    logic                            step_lvl;
    logic                            dir_lvl;
    logic [ssg_pkg::COUNT_WIDTH-1:0] steps_left;
    logic [ssg_pkg::LIMIT_WIDTH-1:0] iv_now;
    logic [ssg_pkg::ADD_WIDTH-1:0]   iv_delta;
    logic [ssg_pkg::LIMIT_WIDTH-1:0] phase;
    pin_state_t                      pin_q[$];
    int                              errors;
    int                              n_items;
    int                              n_started;
    int                              n_rejected;
    int                              n_steps;

    function new();
      min_iv     = ssg_pkg::MIN_INTERVAL_RESET;
      max_iv     = ssg_pkg::MAX_INTERVAL_RESET;
      step_lvl   = 1'b0;
      dir_lvl    = 1'b0;
      steps_left = '0;
      iv_now     = '0;
      iv_delta   = '0;
      phase      = '0;
      errors     = 0;
      n_items    = 0;
      n_started  = 0;
      n_rejected = 0;
      n_steps    = 0;
    endfunction

    function void write_reg(ssg_pkg::cfg_reg_t idx, logic [ssg_pkg::LIMIT_WIDTH-1:0] val);
      case (idx)
        ssg_pkg::REG_MIN_INTERVAL: min_iv = val;
        ssg_pkg::REG_MAX_INTERVAL: max_iv = val;
        default: ;
      endcase
    endfunction

    function bit busy();
      return steps_left != '0;
    endfunction

    function int pending();
      return pin_q.size();
    endfunction

    // Add the signed delta, clamp min then max, saturate to the interval width
    function void ramp_interval();
      longint nxt;
      nxt = longint'(iv_now) + longint'($signed(iv_delta));
      if (nxt < longint'(min_iv)) nxt = longint'(min_iv);
      if (nxt > longint'(max_iv)) nxt = longint'(max_iv);
      if (nxt < 0) nxt = 0;
      iv_now = (nxt > IV_TOP) ? IV_TOP[ssg_pkg::LIMIT_WIDTH-1:0]
                              : nxt[ssg_pkg::LIMIT_WIDTH-1:0];
    endfunction

    function void note_item(ssg_pkg::item_t it);
      pin_state_t ps;
      logic       rej;
      rej = 1'b0;
      n_items++;
      if (it.cmd == ssg_pkg::CMD_LOAD) begin
        if (steps_left != '0) begin
          rej = 1'b1;
          n_rejected++;
        end else if (it.step_count != '0) begin
          iv_now     = it.start_interval;
          steps_left = it.step_count;
          iv_delta   = it.interval_add;
          dir_lvl    = it.direction;
          step_lvl   = 1'b0;
          phase      = '0;
          n_started++;
        end
      end else if (steps_left != '0) begin
        phase = phase + 1'b1;
        if (phase >= iv_now) begin
          phase = '0;
          if (!step_lvl) begin
            step_lvl = 1'b1;
          end else begin
            step_lvl = 1'b0;
            ramp_interval();
            steps_left = steps_left - 1'b1;
            n_steps++;
          end
        end
      end
      ps.step     = step_lvl;
      ps.dir      = dir_lvl;
      ps.busy     = (steps_left != '0);
      ps.rej      = rej;
      ps.interval = iv_now;
      pin_q.push_back(ps);
    endfunction

    function void check_result(pin_state_t got);
      pin_state_t exp_ps;
      if (pin_q.size() == 0) begin
        $error("result transfer with no item outstanding");
        errors++;
        return;
      end
      exp_ps = pin_q.pop_front();
      if (got.step !== exp_ps.step) begin
        $error("step_line expected %0d got %0d", exp_ps.step, got.step);
        errors++;
      end
      if (got.dir !== exp_ps.dir) begin
        $error("direction_line expected %0d got %0d", exp_ps.dir, got.dir);
        errors++;
      end
      if (got.busy !== exp_ps.busy) begin
        $error("busy_res expected %0d got %0d", exp_ps.busy, got.busy);
        errors++;
      end
      if (got.rej !== exp_ps.rej) begin
        $error("rejected expected %0d got %0d", exp_ps.rej, got.rej);
        errors++;
      end
      if (got.interval !== exp_ps.interval) begin
        $error("current_interval expected %0d got %0d", exp_ps.interval, got.interval);
        errors++;
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [ssg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [ssg_pkg::LIMIT_WIDTH-1:0]     cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic                                cmd = 1'b0;
  logic [ssg_pkg::LIMIT_WIDTH-1:0]     seg_start_interval = '0;
  logic [ssg_pkg::COUNT_WIDTH-1:0]     seg_step_count = '0;
  logic [ssg_pkg::ADD_WIDTH-1:0]       seg_interval_add = '0;
  logic                                seg_direction = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic                                step_line;
  logic                                direction_line;
  logic                                busy_res;
  logic                                rejected;
  logic [ssg_pkg::LIMIT_WIDTH-1:0]     current_interval;

  step_gen_scoreboard sb = new();

  bit gaps_on   = 1'b1;
  bit hold_req  = 1'b0;
  int burst_left = 0;

  stepper_segment_step_generator i_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .cmd                (cmd),
    .seg_start_interval (seg_start_interval),
    .seg_step_count     (seg_step_count),
    .seg_interval_add   (seg_interval_add),
    .seg_direction      (seg_direction),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .step_line          (step_line),
    .direction_line     (direction_line),
    .busy_res           (busy_res),
    .rejected           (rejected),
    .current_interval   (current_interval)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    repeat (RUN_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // Check every result transfer against the oldest queued expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result('{step_line, direction_line, busy_res, rejected, current_interval});
    end
  end

  // Stall the result side on shifting patterns; hold off for a long stretch on request
  initial begin : result_sink
    int span;
    int mode;
    int k;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        span = $urandom_range(10, 120);
        mode = $urandom_range(0, 3);
        for (k = 0; k < span; k++) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 99) < 60);
            2: out_ready <= ((k % 4) != 3);
            default: out_ready <= ($urandom_range(0, 99) < 15);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Offer one item, hold it until the transfer, then maybe open a gap
  task automatic push_item(input ssg_pkg::item_t it);
    int gap;
    cmd                <= it.cmd;
    seg_start_interval <= it.start_interval;
    seg_step_count     <= it.step_count;
    seg_interval_add   <= it.interval_add;
    seg_direction      <= it.direction;
    in_valid           <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(it);
    if (gaps_on) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 40);
        in_valid   <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_cfg(input ssg_pkg::cfg_reg_t idx,
                           input logic [ssg_pkg::LIMIT_WIDTH-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every outstanding result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic ssg_pkg::item_t seg_item(logic [ssg_pkg::LIMIT_WIDTH-1:0] start,
                                              logic [ssg_pkg::COUNT_WIDTH-1:0] cnt,
                                              logic [ssg_pkg::ADD_WIDTH-1:0]   add,
                                              logic                            dir);
    ssg_pkg::item_t it;
    it.cmd            = ssg_pkg::CMD_LOAD;
    it.start_interval = start;
    it.step_count     = cnt;
    it.interval_add   = add;
    it.direction      = dir;
    return it;
  endfunction

  function automatic ssg_pkg::item_t noise_item(ssg_pkg::cmd_t c);
    ssg_pkg::item_t it;
    it.cmd            = c;
    it.start_interval = ssg_pkg::LIMIT_WIDTH'($urandom);
    it.step_count     = $urandom;
    it.interval_add   = $urandom;
    it.direction      = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Pick the next item: ticks and rejected loads while moving; segment loads, zero-count loads and ticks while idle
  function automatic ssg_pkg::item_t next_item();
    ssg_pkg::item_t                it;
    int                            r;
    logic [ssg_pkg::ADD_WIDTH-1:0] add;
    r = $urandom_range(0, 99);
    if (sb.busy()) begin
      it = noise_item((r < 90) ? ssg_pkg::CMD_TICK : ssg_pkg::CMD_LOAD);
    end else if (r < 70) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        add = $urandom_range(0, 6) - 3;
      end else if (r < 75) begin
        add = '0;
      end else if (r < 88) begin
        add = $urandom | 32'h8000_0000;
      end else if (sb.max_iv <= 16) begin
        add = $urandom & 32'h7FFF_FFFF;
      end else begin
        add = $urandom_range(1, 3);
      end
      it = seg_item(ssg_pkg::LIMIT_WIDTH'($urandom_range(0, 5)), $urandom_range(1, 6), add,
                    1'($urandom_range(0, 1)));
    end else if (r < 80) begin
      it = noise_item(ssg_pkg::CMD_LOAD);
      it.step_count = '0;
    end else begin
      it = noise_item(ssg_pkg::CMD_TICK);
    end
    return it;
  endfunction

  initial begin : stimulus
    logic [ssg_pkg::LIMIT_WIDTH-1:0] phase_min [NUM_PHASES];
    logic [ssg_pkg::LIMIT_WIDTH-1:0] phase_max [NUM_PHASES];
    ssg_pkg::item_t                  it;
    int                              p;
    int                              sent;
    phase_min = '{31'd1, 31'h7FFF_FFFF, 31'd1, 31'd2, 31'd4};
    phase_max = '{31'h7FFF_FFFF, 31'd3, 31'd1, 31'd9, 31'h4000_0000};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: idle tick with all-ones fields, zero-count load, big add hitting max clamp
    gaps_on = 1'b0;
    it = seg_item('1, '1, '1, 1'b1);
    it.cmd = ssg_pkg::CMD_TICK;
    push_item(it);
    push_item(seg_item('1, '0, '1, 1'b1));
    push_item(seg_item(31'd1, 32'd1, 32'h7FFF_FFFF, 1'b1));
    push_item(seg_item('1, '1, 32'h8000_0000, 1'b1));
    while (sb.busy()) push_item(noise_item(ssg_pkg::CMD_TICK));

    // Directed: zero interval with the most negative add, clamped up to min
    push_item(seg_item('0, 32'd1, 32'h8000_0000, 1'b0));
    while (sb.busy()) push_item(noise_item(ssg_pkg::CMD_TICK));

    // Directed: min above max, cruise segment
    drain();
    write_cfg(ssg_pkg::REG_MIN_INTERVAL, 31'h7FFF_FFFF);
    write_cfg(ssg_pkg::REG_MAX_INTERVAL, 31'd3);
    push_item(seg_item(31'd2, 32'd2, '0, 1'b1));
    it = seg_item('0, '0, '0, 1'b0);
    it.cmd = ssg_pkg::CMD_TICK;
    while (sb.busy()) push_item(it);

    // Random phases, each under its own clamp setting
    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_cfg(ssg_pkg::REG_MIN_INTERVAL, phase_min[p]);
      write_cfg(ssg_pkg::REG_MAX_INTERVAL, phase_max[p]);
      gaps_on    = (p != 0) && (p != 2);
      burst_left = 0;
      if (p == 2) hold_req = 1'b1;
      for (sent = 0; sent < PER_PHASE; sent++) begin
        push_item(next_item());
      end
    end

    drain();
    $display("Covered %0d items: %0d segments started, %0d loads rejected while busy,",
             sb.n_items, sb.n_started, sb.n_rejected);
    $display("%0d steps completed over %0d clamp settings.", sb.n_steps, NUM_PHASES + 2);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/ssg_pkg.sv
sv/ssg_interval_step.sv
sv/stepper_segment_step_generator.sv
sv/ssg_checker.sv
bench/tb_stepper_segment_step_generator.sv
